// ===== src/dsa_pkg.sv =====
// ----------------------------------------------------------------------------
// dsa_pkg
// shared types and constants for decimal scale alignment
// ----------------------------------------------------------------------------
package dsa_pkg;

   // width of a mantissa as carried on the ports
   localparam int MANT_IN_W = 96;
   // limb width of the iterative divide-by-ten unit
   localparam int LIMB_W = 32;
   // floor(2^35 / 10): quotient estimate is exact or one low for inputs below 10 * 2^32
   localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCC;
   localparam int DIV10_SHIFT = 35;

   typedef struct packed {
      logic [63:0] a_mant_low;
      logic [31:0] a_mant_high;
      logic [7:0]  a_scale;
      logic        a_sign;
      logic [63:0] b_mant_low;
      logic [31:0] b_mant_high;
      logic [7:0]  b_scale;
      logic        b_sign;
   } req_type;

   typedef struct packed {
      logic [63:0] a_out_low;
      logic [31:0] a_out_high;
      logic [63:0] b_out_low;
      logic [31:0] b_out_high;
      logic [7:0]  common_scale;
      logic        a_sign_out;
      logic        b_sign_out;
   } rsp_type;

endpackage

// ===== src/dsa_div10_limb.sv =====
// ----------------------------------------------------------------------------
// dsa_div10_limb
// one limb of a long division by ten: {remainder, limb} / 10 by reciprocal
// ----------------------------------------------------------------------------
module dsa_div10_limb (
   input  logic [3:0]                 rem_in,
   input  logic [dsa_pkg::LIMB_W-1:0] limb_in,
   output logic [dsa_pkg::LIMB_W-1:0] quot,
   output logic [3:0]                 rem_out
);
   import dsa_pkg::*;

   localparam int CUR_W  = LIMB_W + 4;
   localparam int PROD_W = CUR_W + LIMB_W;

   logic [CUR_W-1:0]  cur;
   logic [PROD_W-1:0] prod;
   logic [LIMB_W-1:0] q_est;
   logic [CUR_W-1:0]  q_times10;
   logic [CUR_W-1:0]  r_est;

   assign cur  = {rem_in, limb_in};
   assign prod = PROD_W'(cur) * PROD_W'(DIV10_RECIP);
   assign q_est = prod[DIV10_SHIFT +: LIMB_W];

   // ten times the estimate by shift and add
   assign q_times10 = (CUR_W'(q_est) << 3) + (CUR_W'(q_est) << 1);
   assign r_est     = cur - q_times10;

   // estimate is at most one low, so one correction step
   always_comb begin
      if (r_est >= CUR_W'(10)) begin
         quot    = q_est + LIMB_W'(1);
         rem_out = 4'(r_est - CUR_W'(10));
      end else begin
         quot    = q_est;
         rem_out = r_est[3:0];
      end
   end

endmodule

// ===== src/decimal_scale_alignment_top.sv =====
// ----------------------------------------------------------------------------
// decimal_scale_alignment_top
// brings two decimal operands to a common power-of-ten scale
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; busy then stays
// high until the result is shown. rsp_strobe is high for exactly one cycle when
// the result is shown on rsp_data, and the receiver cannot stall it. With equal
// scales the sequencer goes from idle to the done state, which registers the
// result, and the strobe is registered from that state. Otherwise the
// smaller-scale mantissa is multiplied by ten one step per cycle (one shift-add
// unit) until the scales meet or the product would overflow, then the
// larger-scale mantissa is divided by ten with round half to even once per
// remaining scale step; each division walks the LIMBS = ceil(MANTISSA_BITS / 32)
// limbs top down through one shared 32-bit reciprocal divider and then takes
// a rounding step. Mantissa bits at or above MANTISSA_BITS are ignored.
// ----------------------------------------------------------------------------
module decimal_scale_alignment_top #(
   parameter int MANTISSA_BITS = 96
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  dsa_pkg::req_type req_data,
   output logic             busy,
   output logic             rsp_strobe,
   output dsa_pkg::rsp_type rsp_data
);
   import dsa_pkg::*;

   localparam int LIMBS  = (MANTISSA_BITS + LIMB_W - 1) / LIMB_W;
   localparam int WORK_W = LIMBS * LIMB_W;
   localparam int IDX_W  = (LIMBS > 1) ? $clog2(LIMBS) : 1;
   localparam int PROD_W = MANTISSA_BITS + 4;

   // sequencer codes
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MUL   = 3'd1;
   localparam logic [2:0] ST_DIV   = 3'd2;
   localparam logic [2:0] ST_ROUND = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_strobe_ff;
   rsp_type    rsp_ff;

   // working operands: lo holds the smaller-scale operand, hi the larger
   logic [MANTISSA_BITS-1:0] lo_m_ff, hi_m_ff;
   logic [7:0]               lo_scale_ff, hi_scale_ff;
   logic                     swap_ff;      // a had the larger scale
   logic                     a_sign_ff, b_sign_ff;
   logic [IDX_W-1:0]         idx_ff;       // current limb of the division
   logic [3:0]               rem_ff;       // running remainder of the division

   logic                     accept;
   logic                     swap_now;
   logic [MANT_IN_W-1:0]     a_full, b_full;
   logic [MANTISSA_BITS-1:0] a_mask, b_mask;
   logic [PROD_W-1:0]        prod10;
   logic                     fits;
   logic                     scales_met;
   logic [WORK_W-1:0]        work, work_q;
   logic [LIMB_W-1:0]        div_limb, div_q;
   logic [3:0]               div_r;
   logic                     round_up;
   logic [MANTISSA_BITS-1:0] a_res, b_res;
   logic [MANT_IN_W-1:0]     a_res_w, b_res_w;

   // transaction handshake
   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   // input mantissas, masked to the configured width
   assign a_full   = {req_data.a_mant_high, req_data.a_mant_low};
   assign b_full   = {req_data.b_mant_high, req_data.b_mant_low};
   assign a_mask   = a_full[MANTISSA_BITS-1:0];
   assign b_mask   = b_full[MANTISSA_BITS-1:0];
   assign swap_now = (req_data.a_scale > req_data.b_scale);

   // multiply-by-ten unit: 8m + 2m, overflow shows in the top four bits
   assign prod10 = (PROD_W'(lo_m_ff) << 3) + (PROD_W'(lo_m_ff) << 1);
   assign fits   = (prod10[PROD_W-1:MANTISSA_BITS] == 4'd0);
   assign scales_met = (lo_scale_ff == hi_scale_ff);

   // divide-by-ten unit, one limb per cycle from the top
   assign work     = WORK_W'(hi_m_ff);
   assign div_limb = work[idx_ff*LIMB_W +: LIMB_W];

   dsa_div10_limb u_div10 (
      .rem_in  (rem_ff),
      .limb_in (div_limb),
      .quot    (div_q),
      .rem_out (div_r)
   );

   always_comb begin
      work_q = work;
      work_q[idx_ff*LIMB_W +: LIMB_W] = div_q;
   end

   // half to even on the dropped digit alone
   assign round_up = (rem_ff > 4'd5) || ((rem_ff == 4'd5) && hi_m_ff[0]);

   // map working operands back to a and b
   assign a_res   = swap_ff ? hi_m_ff : lo_m_ff;
   assign b_res   = swap_ff ? lo_m_ff : hi_m_ff;
   assign a_res_w = MANT_IN_W'(a_res);
   assign b_res_w = MANT_IN_W'(b_res);

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_data.a_scale == req_data.b_scale) ? ST_DONE : ST_MUL;
            end
         end
         ST_MUL: begin
            if (scales_met) begin
               state_in = ST_DONE;
            end else if (!fits) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (idx_ff == '0) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            // this step brings hi down by one
            state_in = ((hi_scale_ff - 8'd1) == lo_scale_ff) ? ST_DONE : ST_DIV;
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= (state_ff == ST_DONE);
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               swap_ff     <= swap_now;
               lo_m_ff     <= swap_now ? b_mask : a_mask;
               hi_m_ff     <= swap_now ? a_mask : b_mask;
               lo_scale_ff <= swap_now ? req_data.b_scale : req_data.a_scale;
               hi_scale_ff <= swap_now ? req_data.a_scale : req_data.b_scale;
               a_sign_ff   <= req_data.a_sign;
               b_sign_ff   <= req_data.b_sign;
               idx_ff      <= IDX_W'(LIMBS - 1);
               rem_ff      <= 4'd0;
            end
         end
         ST_MUL: begin
            if (!scales_met && fits) begin
               lo_m_ff     <= prod10[MANTISSA_BITS-1:0];
               lo_scale_ff <= lo_scale_ff + 8'd1;
            end
         end
         ST_DIV: begin
            hi_m_ff <= work_q[MANTISSA_BITS-1:0];
            rem_ff  <= div_r;
            idx_ff  <= idx_ff - IDX_W'(1);
         end
         ST_ROUND: begin
            if (round_up) begin
               hi_m_ff <= hi_m_ff + MANTISSA_BITS'(1);
            end
            hi_scale_ff <= hi_scale_ff - 8'd1;
            idx_ff      <= IDX_W'(LIMBS - 1);
            rem_ff      <= 4'd0;
         end
         ST_DONE: begin
            rsp_ff.a_out_low    <= a_res_w[63:0];
            rsp_ff.a_out_high   <= a_res_w[95:64];
            rsp_ff.b_out_low    <= b_res_w[63:0];
            rsp_ff.b_out_high   <= b_res_w[95:64];
            rsp_ff.common_scale <= lo_scale_ff;
            rsp_ff.a_sign_out   <= a_sign_ff;
            rsp_ff.b_sign_out   <= b_sign_ff;
         end
         default: begin
         end
      endcase
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ===== src/dsa_checker.sv =====
// ----------------------------------------------------------------------------
// dsa_checker
// port-level checks of the transaction sequencing
// ----------------------------------------------------------------------------
module dsa_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_strobe,
   input dsa_pkg::rsp_type rsp_data
);
   import dsa_pkg::*;

   // an accepted transaction makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accept");

   // two result strobes never come back to back
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe longer than one cycle");

   // busy ends exactly when the result is shown
   a_busy_fall: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe)
      else $error("busy dropped without a result");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (!busy && $past(busy)))
      else $error("result outside a transaction");

   // the result scale is defined when shown
   a_rsp_known: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !$isunknown(rsp_data.common_scale))
      else $error("result scale unknown");

endmodule

bind decimal_scale_alignment_top dsa_checker u_dsa_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

// ===== tb/sv/tb_decimal_scale_alignment_top.sv =====
// ----------------------------------------------------------------------------
// tb_decimal_scale_alignment_top
// self-checking bench for the decimal scale alignment block
// ----------------------------------------------------------------------------
// Drives operand pairs through the start/busy handshake and computes the
// aligned pair for each accepted transaction in a local model: multiply the
// smaller-scale mantissa by ten while it fits, then divide the other one
// down with round half to even per dropped digit. Every strobed result is
// compared field by field with the oldest pending prediction. Directed
// cases cover equal scales, zero mantissas, the overflow stop, rounding
// ties and carries, and the full scale range; a long random phase follows.
// ----------------------------------------------------------------------------
module tb_decimal_scale_alignment_top;
   timeunit 1ns;
   timeprecision 1ps;

   import dsa_pkg::*;

   localparam int          MANT_BITS    = 96;
   localparam int          RANDOM_ITEMS = 880;
   // cycles allowed for a spurious strobe after the last expected result
   localparam int          DRAIN_CYCLES = 40;
   localparam logic [95:0] MANT_MAX     = {96{1'b1}};
   // largest mantissa that still takes one more multiply by ten
   localparam logic [95:0] MUL_LIMIT    = MANT_MAX / 10;

   logic    clock;
   logic    reset;
   logic    start;
   req_type req_data;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;

   // predicted aligned pairs, oldest first
   rsp_type aligned_pairs_due[$];
   int      fail_count;
   int      sent_count;
   int      checked_count;
   int      divide_count;
   int      widest_gap;

   decimal_scale_alignment_top #(
      .MANTISSA_BITS(MANT_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .busy      (busy),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data)
   );

   // 12 ns clock period
   initial clock = 1'b0;
   always #6 clock = ~clock;

   // ---------------------------------------------------------------------------
   // alignment model
   // ---------------------------------------------------------------------------
   function automatic rsp_type compute_aligned_pair(req_type op);
      logic [95:0] mask;
      logic [95:0] a_m;
      logic [95:0] b_m;
      logic [95:0] up_m;
      logic [95:0] down_m;
      logic [99:0] product;
      logic [95:0] quot;
      logic [95:0] digit;
      int          up_s;
      int          down_s;
      rsp_type     res;
      mask = (MANT_BITS >= 96) ? MANT_MAX : ((96'd1 << MANT_BITS) - 96'd1);
      a_m  = {op.a_mant_high, op.a_mant_low} & mask;
      b_m  = {op.b_mant_high, op.b_mant_low} & mask;
      res  = '0;
      res.a_sign_out = op.a_sign;
      res.b_sign_out = op.b_sign;
      if (op.a_scale == op.b_scale) begin
         res.common_scale = op.a_scale;
      end else begin
         // up side: smaller scale, multiplied; down side: larger scale, divided
         if (op.a_scale < op.b_scale) begin
            up_m = a_m;  up_s = op.a_scale;  down_m = b_m;  down_s = op.b_scale;
         end else begin
            up_m = b_m;  up_s = op.b_scale;  down_m = a_m;  down_s = op.a_scale;
         end
         while (up_s != down_s) begin
            product = {4'd0, up_m} * 100'd10;
            if (product > {4'd0, mask}) break;
            up_m = product[95:0];
            up_s++;
         end
         while (down_s != up_s) begin
            quot  = down_m / 10;
            digit = down_m % 10;
            // round half to even on the dropped digit only
            if (digit > 5 || (digit == 5 && quot[0])) quot = quot + 96'd1;
            down_m = quot;
            down_s--;
         end
         if (op.a_scale < op.b_scale) begin
            a_m = up_m;  b_m = down_m;
         end else begin
            a_m = down_m;  b_m = up_m;
         end
         res.common_scale = up_s[7:0];
      end
      {res.a_out_high, res.a_out_low} = a_m;
      {res.b_out_high, res.b_out_low} = b_m;
      return res;
   endfunction

   // ---------------------------------------------------------------------------
   // driver: one transaction, inputs change on the falling edge
   // ---------------------------------------------------------------------------
   // returns on the falling edge after acceptance with start still high, so a
   // zero gap keeps start asserted straight into the next transaction
   task automatic send_operands(req_type op, int gap);
      int scale_gap;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= op;
      do @(posedge clock); while (busy);
      aligned_pairs_due.push_back(compute_aligned_pair(op));
      sent_count++;
      scale_gap = (op.a_scale > op.b_scale) ? op.a_scale - op.b_scale
                                            : op.b_scale - op.a_scale;
      if (scale_gap > widest_gap) widest_gap = scale_gap;
      @(negedge clock);
   endtask

   function automatic req_type make_pair(logic [95:0] a_m, logic [7:0] a_s, logic a_neg,
                                         logic [95:0] b_m, logic [7:0] b_s, logic b_neg);
      req_type op;
      {op.a_mant_high, op.a_mant_low} = a_m;
      {op.b_mant_high, op.b_mant_low} = b_m;
      op.a_scale = a_s;
      op.b_scale = b_s;
      op.a_sign  = a_neg;
      op.b_sign  = b_neg;
      return op;
   endfunction

   // ---------------------------------------------------------------------------
   // checker: every strobe pops the oldest prediction
   // ---------------------------------------------------------------------------
   task automatic compare_field(string name, logic [95:0] want, logic [95:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (aligned_pairs_due.size() == 0) begin
            $error("result strobe with no pending transaction");
            fail_count++;
         end else begin
            want = aligned_pairs_due.pop_front();
            compare_field("a_out_low",    want.a_out_low,    rsp_data.a_out_low);
            compare_field("a_out_high",   want.a_out_high,   rsp_data.a_out_high);
            compare_field("b_out_low",    want.b_out_low,    rsp_data.b_out_low);
            compare_field("b_out_high",   want.b_out_high,   rsp_data.b_out_high);
            compare_field("common_scale", want.common_scale, rsp_data.common_scale);
            compare_field("a_sign_out",   want.a_sign_out,   rsp_data.a_sign_out);
            compare_field("b_sign_out",   want.b_sign_out,   rsp_data.b_sign_out);
            checked_count++;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // directed tests
   // ---------------------------------------------------------------------------
   // equal scales pass straight through, including the extreme values
   task automatic test_equal_scales();
      send_operands(make_pair(96'd0, 8'd0, 1'b0, 96'd0, 8'd0, 1'b0), $urandom_range(0, 16));
      send_operands(make_pair(MANT_MAX, 8'd255, 1'b1, MANT_MAX, 8'd255, 1'b1),
                    $urandom_range(0, 16));
      send_operands(make_pair(96'd12345, 8'd7, 1'b0, MANT_MAX, 8'd7, 1'b1), 0);
   endtask

   // a zero mantissa multiplies up without limit and meets the larger scale
   task automatic test_zero_mantissa();
      send_operands(make_pair(96'd0, 8'd0, 1'b1, MANT_MAX, 8'd255, 1'b0), $urandom_range(0, 16));
      send_operands(make_pair(96'd999, 8'd200, 1'b0, 96'd0, 8'd3, 1'b1), 0);
      send_operands(make_pair(96'd0, 8'd9, 1'b0, 96'd0, 8'd40, 1'b0), $urandom_range(0, 16));
   endtask

   // multiply phase stops exactly at the overflow boundary
   task automatic test_multiply_overflow();
      send_operands(make_pair(MUL_LIMIT, 8'd0, 1'b0, 96'd77, 8'd5, 1'b0), $urandom_range(0, 16));
      send_operands(make_pair(96'd88, 8'd6, 1'b1, MUL_LIMIT + 96'd1, 8'd2, 1'b0), 0);
      send_operands(make_pair(96'd1, 8'd0, 1'b0, 96'd1, 8'd28, 1'b1), $urandom_range(0, 16));
      send_operands(make_pair(96'd1, 8'd0, 1'b0, 96'd1, 8'd29, 1'b0), 0);
   endtask

   // ties to even, plain round up and down, repeated rounding, carry at max
   task automatic test_rounding_ties();
      send_operands(make_pair(96'd25, 8'd1, 1'b0, MANT_MAX, 8'd0, 1'b0), $urandom_range(0, 16));
      send_operands(make_pair(96'd35, 8'd1, 1'b1, MANT_MAX, 8'd0, 1'b0), 0);
      send_operands(make_pair(MANT_MAX, 8'd0, 1'b0, 96'd26, 8'd1, 1'b0), 0);
      send_operands(make_pair(MANT_MAX, 8'd0, 1'b1, 96'd24, 8'd1, 1'b1), $urandom_range(0, 16));
      send_operands(make_pair(96'd1449, 8'd2, 1'b0, MANT_MAX, 8'd0, 1'b0), 0);
      send_operands(make_pair(96'd155, 8'd2, 1'b0, MANT_MAX, 8'd0, 1'b1), $urandom_range(0, 16));
      send_operands(make_pair(MANT_MAX, 8'd1, 1'b0, MANT_MAX, 8'd0, 1'b0), 0);
   endtask

   // widest scale gaps in both directions against a maximum mantissa, and adjacent scales at the top of the range
   task automatic test_extreme_scales();
      send_operands(make_pair(MANT_MAX, 8'd0, 1'b0, MANT_MAX, 8'd255, 1'b1), $urandom_range(0, 16));
      send_operands(make_pair(MANT_MAX, 8'd255, 1'b1, 96'd5, 8'd0, 1'b0), 0);
      send_operands(make_pair(96'd3, 8'd254, 1'b0, 96'd1, 8'd255, 1'b1), $urandom_range(0, 16));
   endtask

   // ---------------------------------------------------------------------------
   // random test
   // ---------------------------------------------------------------------------
   function automatic logic [95:0] random_mantissa();
      logic [95:0] m;
      case ($urandom_range(0, 5))
         0: m = 96'd0;
         1: m = 96'($urandom_range(0, 999));
         2: m = {$urandom, $urandom, $urandom};
         3: m = {$urandom, $urandom, $urandom} >> $urandom_range(0, 95);
         4: m = MANT_MAX - 96'($urandom_range(0, 15));
         default: m = MUL_LIMIT - 96'd2 + 96'($urandom_range(0, 4));
      endcase
      return m;
   endfunction

   task automatic test_random_mixed();
      req_type op;
      int      base;
      int      other;
      bit      no_idle;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // choose per stretch between back-to-back starts and idle-heavy ones
         if (n % 64 == 0) no_idle = ($urandom_range(0, 2) == 0);
         op = make_pair(random_mantissa(), 8'd0, 1'($urandom),
                        random_mantissa(), 8'd0, 1'($urandom));
         // mostly small scales keep the run short; a few span the full range
         case ($urandom_range(0, 19))
            13, 14, 15: begin
               op.a_scale = 8'($urandom_range(0, 255));
               op.b_scale = op.a_scale;
            end
            16, 17, 18: begin
               base  = $urandom_range(0, 255);
               other = base + $urandom_range(0, 60) - 30;
               if (other < 0) other = 0;
               if (other > 255) other = 255;
               op.a_scale = 8'(base);
               op.b_scale = 8'(other);
            end
            19: begin
               op.a_scale = 8'($urandom_range(0, 255));
               op.b_scale = 8'($urandom_range(0, 255));
            end
            default: begin
               op.a_scale = 8'($urandom_range(0, 28));
               op.b_scale = 8'($urandom_range(0, 28));
            end
         endcase
         if (op.a_scale != op.b_scale) divide_count++;
         send_operands(op, no_idle ? 0 : $urandom_range(0, 16));
      end
   endtask

   // ---------------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------------
   initial begin
      fail_count    = 0;
      sent_count    = 0;
      checked_count = 0;
      divide_count  = 0;
      widest_gap    = 0;
      reset         = 1'b1;
      start         = 1'b0;
      req_data      = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_equal_scales();
      test_zero_mantissa();
      test_multiply_overflow();
      test_rounding_ties();
      test_extreme_scales();
      test_random_mixed();
      start <= 1'b0;

      // every transaction gives one result; then watch for stray strobes
      while (aligned_pairs_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d transactions sent, %0d results checked, widest scale gap %0d",
               sent_count, checked_count, widest_gap);
      $display("%0d random transactions needed alignment work", divide_count);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // watchdog, set well above the worst-case run length
   initial begin
      #60_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
